### sv/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// Shared constants and row types for the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package salru_pkg;

  // Geometry
  localparam int unsigned MAX_SETS   = 256;
  localparam int unsigned MAX_WAYS   = 8;
  localparam int unsigned ADDR_W     = 64;

  localparam int unsigned SET_W      = $clog2(MAX_SETS);
  localparam int unsigned WAY_W      = $clog2(MAX_WAYS);
  localparam int unsigned WAY_CNT_W  = $clog2(MAX_WAYS + 1);
  localparam int unsigned RANK_W     = WAY_W;
  localparam int unsigned TSH_W      = 7;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned META_W     = MAX_WAYS * (1 + RANK_W);
  localparam int unsigned TAG_ROW_W  = MAX_WAYS * ADDR_W;

  localparam logic [3:0]           MAX_SET_BITS = 4'(SET_W);
  localparam logic [WAY_CNT_W-1:0] WAYS_MAX     = WAY_CNT_W'(MAX_WAYS);
  localparam logic [RANK_W-1:0]    RANK_MAX     = RANK_W'(MAX_WAYS - 1);

  // Configuration register indexes
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS  = 2'd2;

  // Request kinds
  localparam logic [1:0] REQ_MODIFY = 2'd2;

  typedef logic [WAY_W-1:0]     way_idx_t;
  typedef logic [WAY_CNT_W-1:0] way_cnt_t;
  typedef logic [RANK_W-1:0]    rank_t;

  // Per-set recency and valid row
  typedef struct packed {
    logic [MAX_WAYS-1:0]        valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
  } meta_row_t;

  typedef logic [MAX_WAYS-1:0][ADDR_W-1:0] tag_row_t;

endpackage

### sv/set_assoc_cache_lru_sim_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_top
// Tag side of a set-associative cache with true LRU replacement and
// saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
// Each request has an accept cycle and a lookup cycle: the accept cycle reads
// the set's tag row and recency row from two synchronous memories, and the
// lookup cycle compares all ways in parallel, picks the hit, fill or victim
// way and writes both rows back. A request is accepted only in the idle cycle
// after a write back, so no new request is taken before the last one has been
// written back. The result sits in an output register; a request may be
// accepted while it waits, but its lookup cycle holds until that register is
// free. Valid and recency are kept per row with a written flag per set in
// flip-flops, so no clearing pass follows reset. Configuration writes are taken
// at any cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_top
  import salru_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [5:0]        cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [ADDR_W-1:0] address_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              was_hit_o,
  output logic              was_miss_o,
  output logic              was_evict_o,
  output logic              extra_hit_o,
  output logic [CNT_W-1:0]  hit_total_o,
  output logic [CNT_W-1:0]  miss_total_o,
  output logic [CNT_W-1:0]  evict_total_o
);

  typedef enum logic {StIdle, StLookup} state_e;

  state_e state_q;

  // configuration (set bits and ways held already clamped)
  logic [3:0]           sb_q;
  way_cnt_t             ways_q;
  logic [5:0]           blk_q;

  // request held across the lookup
  logic [1:0]           req_type_q;
  logic [ADDR_W-1:0]    tag_q;
  logic [SET_W-1:0]     set_q;
  logic                 row_ok_q;
  logic [MAX_SETS-1:0]  row_written_q;

  // result register and totals
  logic                 out_valid_q;
  logic                 was_hit_q, was_miss_q, was_evict_q, extra_hit_q;
  logic [CNT_W-1:0]     hit_cnt_q, miss_cnt_q, evict_cnt_q;

  logic                 accept;
  logic                 done;

  // address split
  logic [ADDR_W-1:0]    addr_shifted;
  logic [SET_W:0]       set_mask;
  logic [SET_W-1:0]     set_idx;
  logic [TSH_W-1:0]     tag_shift;
  logic [ADDR_W-1:0]    tag_d;

  // memory rows
  logic [META_W-1:0]    meta_rdata;
  logic [TAG_ROW_W-1:0] tag_rdata;
  meta_row_t            rd_meta;
  tag_row_t             rd_tags;
  meta_row_t            new_meta;
  tag_row_t             new_tags;

  // lookup
  logic [MAX_WAYS-1:0]  way_valid, in_use, hit_vec, free_vec;
  rank_t                way_rank [MAX_WAYS];
  logic                 hit_any, free_any, fresh;
  way_idx_t             hit_way, free_way, victim, touch_way;
  rank_t                old_rank;

  // totals
  logic [1:0]           hit_inc;
  logic [CNT_W:0]       hit_sum;
  logic [CNT_W-1:0]     hit_cnt_d, miss_cnt_d, evict_cnt_d;

  assign accept     = in_valid_i && (state_q == StIdle);
  assign done       = (state_q == StLookup) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = (state_q != StIdle);

  // Split the incoming address into set index and tag
  always_comb begin
    addr_shifted = address_i >> blk_q;
    set_mask     = (SET_W + 1)'((SET_W + 1)'(1) << sb_q) - (SET_W + 1)'(1);
    set_idx      = addr_shifted[SET_W-1:0] & set_mask[SET_W-1:0];
    tag_shift    = TSH_W'(blk_q) + TSH_W'(sb_q);
    tag_d        = (tag_shift >= TSH_W'(ADDR_W)) ? '0 : (address_i >> tag_shift);
  end

  salru_ram #(
    .Width (META_W),
    .Depth (MAX_SETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (done),
    .waddr_i (set_q),
    .wdata_i (new_meta),
    .re_i    (accept),
    .raddr_i (set_idx),
    .rdata_o (meta_rdata)
  );

  salru_ram #(
    .Width (TAG_ROW_W),
    .Depth (MAX_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (done),
    .waddr_i (set_q),
    .wdata_i (new_tags),
    .re_i    (accept),
    .raddr_i (set_idx),
    .rdata_o (tag_rdata)
  );

  assign rd_meta = meta_row_t'(meta_rdata);
  assign rd_tags = tag_row_t'(tag_rdata);

  // Compare all ways, choose the touched way and build the new rows
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      way_valid[i] = row_ok_q && rd_meta.valid[i];
      way_rank[i]  = row_ok_q ? rd_meta.rank[i] : '0;
      in_use[i]    = (way_cnt_t'(i) < ways_q);
      hit_vec[i]   = in_use[i] && way_valid[i] && (rd_tags[i] == tag_q);
      free_vec[i]  = in_use[i] && !way_valid[i];
    end
    hit_any  = |hit_vec;
    free_any = |free_vec;

    // lowest-numbered hit and free way
    hit_way  = '0;
    free_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_way = way_idx_t'(i);
      end
      if (free_vec[i]) begin
        free_way = way_idx_t'(i);
      end
    end

    // highest rank wins, lowest index on a tie
    victim = '0;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && (way_rank[i] > way_rank[victim])) begin
        victim = way_idx_t'(i);
      end
    end

    touch_way = hit_any ? hit_way : (free_any ? free_way : victim);
    fresh     = !hit_any && free_any;
    old_rank  = way_rank[touch_way];

    // age the lines that were more recent than the touched one, or every valid line on a fill
    for (int i = 0; i < MAX_WAYS; i++) begin
      new_meta.valid[i] = way_valid[i];
      new_meta.rank[i]  = way_rank[i];
      if (in_use[i] && way_valid[i] && (way_idx_t'(i) != touch_way) &&
          (fresh || (way_rank[i] < old_rank)) && (way_rank[i] != RANK_MAX)) begin
        new_meta.rank[i] = way_rank[i] + rank_t'(1);
      end
    end
    new_meta.valid[touch_way] = 1'b1;
    new_meta.rank[touch_way]  = '0;

    new_tags            = rd_tags;
    new_tags[touch_way] = tag_q;
  end

  // Saturating totals
  always_comb begin
    hit_inc     = 2'(hit_any) + 2'(req_type_q == REQ_MODIFY);
    hit_sum     = {1'b0, hit_cnt_q} + (CNT_W + 1)'(hit_inc);
    hit_cnt_d   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    if (!hit_any && (miss_cnt_q != '1)) begin
      miss_cnt_d = miss_cnt_q + CNT_W'(1);
    end
    if (!hit_any && !free_any && (evict_cnt_q != '1)) begin
      evict_cnt_d = evict_cnt_q + CNT_W'(1);
    end
  end

  // Take configuration writes; set bits and ways are clamped to the supported range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q   <= '0;
      ways_q <= way_cnt_t'(1);
      blk_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS: begin
          sb_q <= (cfg_wdata_i[3:0] > MAX_SET_BITS) ? MAX_SET_BITS : cfg_wdata_i[3:0];
        end
        CFG_WAYS_IN_USE: begin
          if (cfg_wdata_i[3:0] == 4'd0) begin
            ways_q <= way_cnt_t'(1);
          end else if (way_cnt_t'(cfg_wdata_i[3:0]) > WAYS_MAX) begin
            ways_q <= WAYS_MAX;
          end else begin
            ways_q <= way_cnt_t'(cfg_wdata_i[3:0]);
          end
        end
        CFG_BLOCK_BITS: begin
          blk_q <= cfg_wdata_i;
        end
        default: begin
        end
      endcase
    end
  end

  // Mark a set's row as written once its first write back lands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_written_q <= '0;
    end else if (done) begin
      row_written_q[set_q] <= 1'b1;
    end
  end

  // Hold the request for its lookup cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_type_i;
      tag_q      <= tag_d;
      set_q      <= set_idx;
      row_ok_q   <= row_written_q[set_idx];
    end
  end

  // Sequence the request and load the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      was_hit_q   <= 1'b0;
      was_miss_q  <= 1'b0;
      was_evict_q <= 1'b0;
      extra_hit_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !done) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StLookup;
          end
        end
        StLookup: begin
          if (done) begin
            state_q     <= StIdle;
            out_valid_q <= 1'b1;
            was_hit_q   <= hit_any;
            was_miss_q  <= !hit_any;
            was_evict_q <= !hit_any && !free_any;
            extra_hit_q <= (req_type_q == REQ_MODIFY);
            hit_cnt_q   <= hit_cnt_d;
            miss_cnt_q  <= miss_cnt_d;
            evict_cnt_q <= evict_cnt_d;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign was_hit_o     = was_hit_q;
  assign was_miss_o    = was_miss_q;
  assign was_evict_o   = was_evict_q;
  assign extra_hit_o   = extra_hit_q;
  assign hit_total_o   = hit_cnt_q;
  assign miss_total_o  = miss_cnt_q;
  assign evict_total_o = evict_cnt_q;

  // Checks
  a_accept_to_lookup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StLookup))
    else $error("accepted request did not enter lookup");

  a_done_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> ((state_q == StIdle) && out_valid_q))
    else $error("finished lookup did not load a result");

  a_hit_xor_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (was_hit_q != was_miss_q))
    else $error("result is not exactly one of hit and miss");

  a_evict_on_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && was_evict_q) |-> was_miss_q)
    else $error("eviction without a miss");

  a_totals_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(hit_cnt_q) &&
                                      $stable(miss_cnt_q) && $stable(evict_cnt_q)))
    else $error("totals moved while a result waits");

endmodule

### sv/salru_ram.sv
// ----------------------------------------------------------------------------
// salru_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module salru_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and read on request (a read of the word being written gets the old word); read data holds between reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set-associative LRU cache tag block.
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the tag, valid and recency stores,
// the geometry registers and the running totals. It works out the expected
// result of every accepted request and compares each result, field by field,
// in order. A directed part covers the register extremes, every request kind,
// tag and set corner cases and LRU victim choice. Random phases follow, each
// with a fresh geometry and a small pool of addresses so that hits, fills and
// evictions all occur. Both sides idle at random, with one calm phase, one
// long result hold-off and a drain before every register write.
// ----------------------------------------------------------------------------
module testbench;
  import salru_pkg::*;

  localparam int LINES        = MAX_SETS * MAX_WAYS;
  localparam int RANDOM_ITEMS = 1700;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 100;

  // Request kinds not named in the package
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_ODD   = 2'd3;

  // Register index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             evict;
    logic             extra;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } lookup_t;

  // --------------------------------------------------------------------------
  // Scoreboard: cache tag predictor and queue of expected lookups
  // --------------------------------------------------------------------------
  class lru_scoreboard;
    logic [ADDR_W-1:0] tag_mem  [LINES];
    bit                line_ok  [LINES];
    rank_t             rank_mem [LINES];
    logic [CNT_W-1:0]  hits, misses, evicts;
    logic [3:0]        set_bits_q;
    logic [3:0]        ways_q;
    logic [5:0]        block_bits_q;
    lookup_t           lookups_q[$];
    int                errors;

    function new();
      for (int i = 0; i < LINES; i++) begin
        line_ok[i]  = 1'b0;
        rank_mem[i] = '0;
      end
      hits         = '0;
      misses       = '0;
      evicts       = '0;
      set_bits_q   = 4'd0;
      ways_q       = 4'd1;
      block_bits_q = 6'd0;
      errors       = 0;
    endfunction

    function int pending();
      return lookups_q.size();
    endfunction

    function void write_reg(logic [1:0] idx, logic [5:0] val);
      case (idx)
        CFG_SET_BITS:    set_bits_q   = val[3:0];
        CFG_WAYS_IN_USE: ways_q       = val[3:0];
        CFG_BLOCK_BITS:  block_bits_q = val;
        default: ;
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // Make the touched line most recent; age the younger valid lines, or all valid lines on a fill
    function void promote(int base, int ways, int way, bit fresh);
      rank_t old;
      old = rank_mem[base + way];
      for (int i = 0; i < ways; i++) begin
        if (i != way && line_ok[base + i] && (fresh || rank_mem[base + i] < old)) begin
          if (rank_mem[base + i] < RANK_MAX) rank_mem[base + i] = rank_mem[base + i] + 1'b1;
        end
      end
      rank_mem[base + way] = '0;
    endfunction

    // Look the request up, update the stores and queue the expected lookup
    function void note_request(logic [1:0] kind, logic [ADDR_W-1:0] addr);
      lookup_t           r;
      int                sb, ways, tsh, set_idx, base, way, victim;
      logic [ADDR_W-1:0] tag;
      r    = '0;
      sb   = (set_bits_q > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_q;
      ways = (ways_q == 0) ? 1 : ((ways_q > MAX_WAYS) ? MAX_WAYS : ways_q);
      set_idx = int'((addr >> block_bits_q) & ((64'd1 << sb) - 64'd1));
      tsh  = block_bits_q + sb;
      tag  = (tsh >= ADDR_W) ? '0 : (addr >> tsh);
      base = (set_idx % MAX_SETS) * MAX_WAYS;

      way = ways;
      for (int i = 0; i < ways; i++) begin
        if (way == ways && line_ok[base + i] && tag_mem[base + i] == tag) way = i;
      end

      if (way < ways) begin
        r.hit = 1'b1;
        hits  = bump(hits);
        promote(base, ways, way, 1'b0);
      end else begin
        r.miss = 1'b1;
        misses = bump(misses);
        for (int i = 0; i < ways; i++) begin
          if (way == ways && !line_ok[base + i]) way = i;
        end
        if (way < ways) begin
          tag_mem[base + way] = tag;
          line_ok[base + way] = 1'b1;
          promote(base, ways, way, 1'b1);
        end else begin
          // Oldest line goes; the lowest way wins a tie
          victim = 0;
          for (int i = 1; i < ways; i++) begin
            if (rank_mem[base + i] > rank_mem[base + victim]) victim = i;
          end
          tag_mem[base + victim] = tag;
          promote(base, ways, victim, 1'b0);
          r.evict = 1'b1;
          evicts  = bump(evicts);
        end
      end

      if (kind == REQ_MODIFY) begin
        r.extra = 1'b1;
        hits    = bump(hits);
      end
      r.hit_total   = hits;
      r.miss_total  = misses;
      r.evict_total = evicts;
      lookups_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want) begin
        errors++;
        // Keep the log short when the block is badly off
        if (errors <= MAX_REPORTS)
          $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(lookup_t got);
      lookup_t want;
      if (lookups_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with no request waiting, expected none actual %h", $time, got);
      end else begin
        want = lookups_q.pop_front();
        compare_field("was_hit", want.hit, got.hit);
        compare_field("was_miss", want.miss, got.miss);
        compare_field("was_evict", want.evict, got.evict);
        compare_field("extra_hit", want.extra, got.extra);
        compare_field("hit_total", want.hit_total, got.hit_total);
        compare_field("miss_total", want.miss_total, got.miss_total);
        compare_field("evict_total", want.evict_total, got.evict_total);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block
  // --------------------------------------------------------------------------
  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [1:0]        cfg_idx_i   = '0;
  logic [5:0]        cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [1:0]        req_type_i  = '0;
  logic [ADDR_W-1:0] address_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              was_hit_o;
  logic              was_miss_o;
  logic              was_evict_o;
  logic              extra_hit_o;
  logic [CNT_W-1:0]  hit_total_o;
  logic [CNT_W-1:0]  miss_total_o;
  logic [CNT_W-1:0]  evict_total_o;

  lru_scoreboard scoreboard = new();
  int            idle_pct   = 11;
  bit            hold_req   = 1'b0;

  set_assoc_cache_lru_sim_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .was_hit_o     (was_hit_o),
    .was_miss_o    (was_miss_o),
    .was_evict_o   (was_evict_o),
    .extra_hit_o   (extra_hit_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o),
    .evict_total_o (evict_total_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Request driving
  // --------------------------------------------------------------------------
  // Offer one request, idling first at random, and hold it until accepted
  task automatic issue_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    address_i  <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    scoreboard.note_request(kind, addr);
  endtask

  // Stop offering and wait until every expected lookup has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (scoreboard.pending() != 0) @(posedge clk_i);
  endtask

  // Drain, then write all three registers in a randomly rotated order, and the spare index last if asked
  task automatic reconfigure(input logic [3:0] sb, input logic [3:0] ways,
                             input logic [5:0] bb, input bit spare);
    logic [1:0] order [3];
    logic [5:0] vals  [4];
    logic [1:0] idx;
    int         first;
    order = '{CFG_SET_BITS, CFG_WAYS_IN_USE, CFG_BLOCK_BITS};
    // Upper data bits of the narrow registers carry noise
    vals[CFG_SET_BITS]    = {2'($urandom_range(0, 3)), sb};
    vals[CFG_WAYS_IN_USE] = {2'($urandom_range(0, 3)), ways};
    vals[CFG_BLOCK_BITS]  = bb;
    vals[CFG_SPARE]       = 6'($urandom_range(0, 63));
    first = $urandom_range(0, 2);
    wait_for_results();
    for (int j = 0; j < 3 + int'(spare); j++) begin
      idx = (j < 3) ? order[(first + j) % 3] : CFG_SPARE;
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= vals[idx];
      @(posedge clk_i);
      scoreboard.write_reg(idx, vals[idx]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, one long hold-off, check every result
  // --------------------------------------------------------------------------
  initial begin : result_side
    lookup_t got;
    int      hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = {was_hit_o, was_miss_o, was_evict_o, extra_hit_o,
               hit_total_o, miss_total_o, evict_total_o};
        scoreboard.check_result(got);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("set_assoc_cache_lru_sim_top: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [ADDR_W-1:0] addr_pool [32];
    logic [ADDR_W-1:0] offset_mask;
    logic [ADDR_W-1:0] addr;
    logic [3:0]        sb, ways;
    logic [5:0]        bb;
    int                sent, phase, n_items, pool_size;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: one set, one way, no offset
    issue_request(REQ_LOAD, '0);
    issue_request(REQ_LOAD, '0);
    issue_request(REQ_STORE, '1);
    issue_request(REQ_MODIFY, '1);
    issue_request(REQ_ODD, '0);

    // Set bits and ways above range, offset plus index past the address width
    reconfigure(4'd15, 4'd15, 6'd63, 1'b0);
    issue_request(REQ_LOAD, 64'h8000_0000_0000_0000);
    issue_request(REQ_LOAD, '0);
    issue_request(REQ_MODIFY, 64'h8000_0000_0000_0001);

    // Zero ways, offset plus index exactly at the address width
    reconfigure(4'd8, 4'd0, 6'd56, 1'b0);
    issue_request(REQ_LOAD, 64'hAB00_0000_0000_0000);
    issue_request(REQ_STORE, 64'hAB12_3456_789A_BCDE);

    // Three ways in one set: fill, refresh, evict the oldest
    reconfigure(4'd0, 4'd3, 6'd0, 1'b0);
    issue_request(REQ_LOAD, 64'd1);
    issue_request(REQ_LOAD, 64'd2);
    issue_request(REQ_LOAD, 64'd3);
    issue_request(REQ_LOAD, 64'd1);
    issue_request(REQ_STORE, 64'd4);
    issue_request(REQ_LOAD, 64'd2);
    issue_request(REQ_MODIFY, 64'd1);

    // Widen to four ways, then shrink to two over stale ranks
    reconfigure(4'd0, 4'd4, 6'd0, 1'b0);
    issue_request(REQ_LOAD, 64'd5);
    issue_request(REQ_LOAD, 64'd3);
    reconfigure(4'd0, 4'd2, 6'd0, 1'b1);
    issue_request(REQ_LOAD, 64'd9);

    // Random phases, each with its own geometry and address pool
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      sb   = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
      ways = ($urandom_range(0, 99) < 80) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0:       bb = 6'($urandom_range(41, 63));
        1, 2:    bb = 6'($urandom_range(9, 40));
        default: bb = 6'($urandom_range(0, 8));
      endcase
      reconfigure(sb, ways, bb, ($urandom_range(0, 9) == 0));

      idle_pct = (phase == 2) ? 0 : 11;
      if (phase == 4) hold_req = 1'b1;

      pool_size = $urandom_range(1, 24);
      for (int k = 0; k < pool_size; k++) addr_pool[k] = rand_word();
      offset_mask = (64'd1 << bb) - 64'd1;

      n_items = $urandom_range(60, 140);
      for (int k = 0; k < n_items; k++) begin
        // Mostly pool lines with a random offset, the rest raw addresses
        if ($urandom_range(0, 99) < 15) addr = rand_word();
        else addr = addr_pool[$urandom_range(0, pool_size - 1)] ^ (rand_word() & offset_mask);
        issue_request(2'($urandom_range(0, 3)), addr);
        sent++;
      end
      phase++;
    end

    // Drain, then allow a late stray result to show up
    wait_for_results();
    repeat (8) @(posedge clk_i);

    if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
      $display("set_assoc_cache_lru_sim_top: match");
    end else begin
      $display("set_assoc_cache_lru_sim_top: mismatch");
    end
    $finish;
  end

endmodule
